/* rtl/ksl_pkg.sv */
// ============================================================================
// ksl_pkg
// Shared widths, item kinds and result status codes of the keyed slot table.
// ============================================================================
package ksl_pkg;

    localparam int KEY_W  = 32;
    localparam int TIME_W = 32;
    localparam int DUR_W  = 16;
    localparam int KIND_W = 2;
    localparam int STAT_W = 3;
    localparam int OIDX_W = 3;
    localparam int CFG_W  = 8;

    localparam int          SLOT_COUNT_DEF = 8;
    localparam logic [7:0]  WARMUP_RESET   = 8'd5;

    localparam logic [KIND_W-1:0] KIND_SHOW  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HIDE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd3;

    localparam logic [STAT_W-1:0] ST_REUSED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_NEW     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EVICTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_WARMUP  = 3'd4;
    localparam logic [STAT_W-1:0] ST_FREED   = 3'd5;
    localparam logic [STAT_W-1:0] ST_NOTHING = 3'd6;

endpackage

/* rtl/ksl_if.sv */
// ============================================================================
// ksl_if
// Request and result channels of the keyed slot table, valid/ready handshake.
// ============================================================================
interface ksl_in_if;
    logic                        valid;
    logic                        ready;
    logic [ksl_pkg::KIND_W-1:0]  kind;
    logic [ksl_pkg::KEY_W-1:0]   client_key;
    logic [ksl_pkg::DUR_W-1:0]   duration;

    modport source (output valid, kind, client_key, duration, input ready);
    modport sink   (input valid, kind, client_key, duration, output ready);
endinterface

interface ksl_out_if;
    logic                        valid;
    logic                        ready;
    logic [ksl_pkg::OIDX_W-1:0]  slot_index;
    logic [ksl_pkg::STAT_W-1:0]  status;
    logic [ksl_pkg::TIME_W-1:0]  expire_time;
    logic                        last;

    modport source (output valid, slot_index, status, expire_time, last, input ready);
    modport sink   (input valid, slot_index, status, expire_time, last, output ready);
endinterface

/* rtl/keyed_slot_table_with_expiry.sv */
// ============================================================================
// keyed_slot_table_with_expiry
// Slot table keyed by client key, with expiry by tick and eviction of the
// earliest expired slot.
// ============================================================================
// Usage:
//   i_in carries one request item (kind, client_key, duration): show, hide,
//   clear all or a one-second tick. o_out returns one or more result items
//   per request (slot_index, status, expire_time, last); last marks the
//   final result of the request. i_cfg_we/i_cfg_data write warmup_ticks.
//   A request is scanned by a token that walks the row of slot cells, one
//   cell per cycle while o_out is not stalled; the token is registered at
//   the input and in each cell, and the final result of an item is offered
//   on o_out from the output register. One request is in flight at a
//   time; the next is taken once the final result of the current one has
//   entered the output register.
//   Freed slots of a hide, clear or tick are reported as the token passes.
//   When the receiver stalls o_out, the token and all slot state hold.
//   Reset (synchronous, active low) empties all slots, sets the time to
//   zero, restarts the warmup and sets warmup_ticks to 5.
// ============================================================================
module keyed_slot_table_with_expiry #(
    parameter int SLOT_COUNT = ksl_pkg::SLOT_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ksl_in_if.sink                     i_in,
    ksl_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [ksl_pkg::CFG_W-1:0]  i_cfg_data
);
    import ksl_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [DUR_W-1:0]  dur;
        logic              found_v;
        logic [IW-1:0]     found_idx;
        logic              free_v;
        logic [IW-1:0]     free_idx;
        logic              best_v;
        logic [IW-1:0]     best_idx;
        logic [TIME_W-1:0] best_exp;
        logic              pend_v;
        logic [IW-1:0]     pend_idx;
    } t_tok;

    typedef struct packed {
        logic              en;
        logic [IW-1:0]     idx;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] exp;
    } t_wr;

    logic [CFG_W-1:0]  r_warmup;
    logic [TIME_W-1:0] r_time;
    logic              r_warming;
    logic              r_busy;
    t_tok              r_tok0;
    t_tok              n_tok0;
    t_tok              tok [0:SLOT_COUNT];
    logic [SLOT_COUNT-1:0] emit;
    t_wr               wr;

    logic              r_o_valid;
    logic [OIDX_W-1:0] r_o_idx;
    logic [STAT_W-1:0] r_o_stat;
    logic [TIME_W-1:0] r_o_exp;
    logic              r_o_last;

    logic              stall;
    logic              accept;
    logic [TIME_W-1:0] n_time;
    logic [TIME_W:0]   exp_sum;
    logic [TIME_W-1:0] show_exp;
    t_tok              fin;
    logic              load;
    logic [IW-1:0]     load_idx;
    logic [IW+2:0]     load_idx_ext;
    logic [STAT_W-1:0] load_stat;
    logic [TIME_W-1:0] load_exp;
    logic              load_last;
    logic              emit_any;
    logic [IW-1:0]     emit_idx;

    assign stall      = r_o_valid && !o_out.ready;
    assign i_in.ready = !r_busy && i_rst_n;
    assign accept     = i_in.valid && i_in.ready;
    assign n_time     = (r_time == '1) ? r_time : r_time + TIME_W'(1);

    assign tok[0] = r_tok0;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        ksl_cell #(
            .SLOT_COUNT (SLOT_COUNT),
            .CELL_IDX   (g),
            .t_tok      (t_tok),
            .t_wr       (t_wr)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stall (stall),
            .i_time  (r_time),
            .i_tok   (tok[g]),
            .i_wr    (wr),
            .o_tok   (tok[g+1]),
            .o_emit  (emit[g])
        );
    end

    // only the cell holding the token can raise emit
    always_comb begin
        emit_any = 1'b0;
        emit_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            emit_any = emit_any | emit[i];
            emit_idx = emit_idx | (emit[i] ? tok[i].pend_idx : '0);
        end
    end

    assign fin      = tok[SLOT_COUNT];
    assign exp_sum  = {1'b0, r_time} + (TIME_W + 1)'(fin.dur);
    assign show_exp = (fin.dur == '0) ? '0 :
                      (exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0]);

    always_comb begin
        load      = 1'b0;
        load_idx  = '0;
        load_stat = ST_NOTHING;
        load_exp  = '0;
        load_last = 1'b0;
        wr.en     = 1'b0;
        wr.idx    = '0;
        wr.key    = fin.key;
        wr.exp    = show_exp;
        if (fin.valid) begin
            load      = 1'b1;
            load_last = 1'b1;
            if (fin.kind == KIND_SHOW) begin
                if (r_warming) begin
                    load_stat = ST_WARMUP;
                end else if (fin.found_v) begin
                    load_stat = ST_REUSED;
                    load_idx  = fin.found_idx;
                end else if (fin.free_v) begin
                    load_stat = ST_NEW;
                    load_idx  = fin.free_idx;
                end else if (fin.best_v) begin
                    load_stat = ST_EVICTED;
                    load_idx  = fin.best_idx;
                end else begin
                    load_stat = ST_FULL;
                end
                if (!r_warming && (fin.found_v || fin.free_v || fin.best_v)) begin
                    load_exp = show_exp;
                    wr.en    = !stall;
                    wr.idx   = load_idx;
                end
            end else if (fin.pend_v) begin
                load_stat = ST_FREED;
                load_idx  = fin.pend_idx;
            end
        end else if (emit_any) begin
            load      = 1'b1;
            load_stat = ST_FREED;
            load_idx  = emit_idx;
        end
    end

    assign load_idx_ext = {3'b000, load_idx};

    always_comb begin
        n_tok0       = '0;
        n_tok0.valid = 1'b1;
        n_tok0.kind  = i_in.kind;
        n_tok0.key   = i_in.client_key;
        n_tok0.dur   = i_in.duration;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup     <= WARMUP_RESET;
            r_time       <= '0;
            r_warming    <= 1'b1;
            r_busy       <= 1'b0;
            r_tok0.valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_warmup <= i_cfg_data;
            end
            if (accept) begin
                r_busy <= 1'b1;
                r_tok0 <= n_tok0;
                if (i_in.kind == KIND_TICK) begin
                    r_time <= n_time;
                    if (n_time >= TIME_W'(r_warmup)) begin
                        r_warming <= 1'b0;
                    end
                end
            end else if (!stall) begin
                r_tok0.valid <= 1'b0;
            end
            if (!stall) begin
                r_o_valid <= load;
                if (fin.valid) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall && load) begin
            r_o_idx  <= load_idx_ext[OIDX_W-1:0];
            r_o_stat <= load_stat;
            r_o_exp  <= load_exp;
            r_o_last <= load_last;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.slot_index  = r_o_idx;
    assign o_out.status      = r_o_stat;
    assign o_out.expire_time = r_o_exp;
    assign o_out.last        = r_o_last;

endmodule

/* rtl/ksl_cell.sv */
// ============================================================================
// ksl_cell
// One slot of the table: holds used/key/expiry, updates the passing scan
// token and hands it to the next cell.
// ============================================================================
module ksl_cell #(
    parameter int  SLOT_COUNT = ksl_pkg::SLOT_COUNT_DEF,
    parameter int  CELL_IDX   = 0,
    parameter type t_tok      = logic,
    parameter type t_wr       = logic
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_stall,
    input  logic [ksl_pkg::TIME_W-1:0]  i_time,
    input  t_tok                        i_tok,
    input  t_wr                         i_wr,
    output t_tok                        o_tok,
    output logic                        o_emit
);
    import ksl_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] ME = IW'(CELL_IDX);

    logic              r_used;
    logic [KEY_W-1:0]  r_key;
    logic [TIME_W-1:0] r_exp;
    t_tok              r_tok;
    t_tok              n_tok;

    logic match;
    logic expd;
    logic free_this;

    always_comb begin
        match     = r_used && (r_key == i_tok.key);
        expd      = r_used && (r_exp != '0) && (r_exp <= i_time);
        free_this = 1'b0;
        o_emit    = 1'b0;
        n_tok     = i_tok;
        if (i_tok.valid) begin
            case (i_tok.kind)
                KIND_HIDE:  free_this = match;
                KIND_CLEAR: free_this = r_used;
                KIND_TICK:  free_this = expd;
                default: begin
                    if (match && !i_tok.found_v) begin
                        n_tok.found_v   = 1'b1;
                        n_tok.found_idx = ME;
                    end
                    if (!r_used && !i_tok.free_v) begin
                        n_tok.free_v   = 1'b1;
                        n_tok.free_idx = ME;
                    end
                    if (expd && (!i_tok.best_v || (r_exp < i_tok.best_exp))) begin
                        n_tok.best_v   = 1'b1;
                        n_tok.best_idx = ME;
                        n_tok.best_exp = r_exp;
                    end
                end
            endcase
        end
        // the previous freed slot is sent on once a later one shows up
        if (free_this) begin
            o_emit         = i_tok.pend_v;
            n_tok.pend_v   = 1'b1;
            n_tok.pend_idx = ME;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            if (!i_stall) begin
                r_tok <= n_tok;
            end
            if (i_wr.en && (i_wr.idx == ME)) begin
                r_used <= 1'b1;
            end else if (!i_stall && free_this) begin
                r_used <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == ME)) begin
            r_key <= i_wr.key;
            r_exp <= i_wr.exp;
        end
    end

    assign o_tok = r_tok;

endmodule

/* tb/tb_keyed_slot_table_with_expiry.sv */
// ============================================================================
// tb_keyed_slot_table_with_expiry
// Self-checking testbench for the keyed slot table with expiry. A slot table
// predictor runs beside the block and computes the result items of every
// accepted request item. Requests are sent in random bursts while the result
// side stalls on its own pattern. The stimulus covers warmup, show, hide,
// clear and tick traffic, one long output hold-off, and warmup_ticks settings.
// ============================================================================
module tb_keyed_slot_table_with_expiry;
    timeunit 1ns;
    timeprecision 1ps;

    import ksl_pkg::*;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 2 * SLOTS + 8;

    typedef struct {
        logic [OIDX_W-1:0] slot_index;
        logic [STAT_W-1:0] status;
        logic [TIME_W-1:0] expire_time;
        logic              last;
    } t_slot_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_data;

    ksl_in_if  in_if ();
    ksl_out_if out_if ();

    keyed_slot_table_with_expiry #(
        .SLOT_COUNT (SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // slot table as the predictor sees it
    logic              tbl_used   [SLOTS];
    logic [KEY_W-1:0]  tbl_key    [SLOTS];
    logic [TIME_W-1:0] tbl_expiry [SLOTS];
    logic [TIME_W-1:0] tbl_now;
    logic              tbl_warming;
    logic [CFG_W-1:0]  warmup_cfg;

    t_slot_result results_due[$];

    int  errors         = 0;
    int  cycles         = 0;
    int  requests_sent;
    int  results_seen   = 0;
    int  status_seen[7] = '{default: 0};
    bit  hold_off_req   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, results_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic bit slot_expired(int i);
        return tbl_used[i] && tbl_expiry[i] != '0 && tbl_expiry[i] <= tbl_now;
    endfunction

    function automatic void add_result(int idx, logic [STAT_W-1:0] st,
                                       logic [TIME_W-1:0] et);
        t_slot_result r;
        r.slot_index  = idx[OIDX_W-1:0];
        r.status      = st;
        r.expire_time = et;
        r.last        = 1'b0;
        results_due.push_back(r);
    endfunction

    function automatic void release_slot(int i);
        tbl_used[i]   = 1'b0;
        tbl_key[i]    = '0;
        tbl_expiry[i] = '0;
        add_result(i, ST_FREED, '0);
    endfunction

    function automatic void predict_request(logic [KIND_W-1:0] kind,
                                            logic [KEY_W-1:0] key,
                                            logic [DUR_W-1:0] dur);
        int                pick;
        int                n0;
        logic [STAT_W-1:0] st;
        logic [TIME_W-1:0] et;
        logic [TIME_W-1:0] dur_w;

        n0    = results_due.size();
        dur_w = {{(TIME_W-DUR_W){1'b0}}, dur};
        pick  = -1;
        case (kind)
            KIND_SHOW: begin
                if (tbl_warming) begin
                    add_result(0, ST_WARMUP, '0);
                end else begin
                    for (int i = 0; i < SLOTS; i++)
                        if (pick < 0 && tbl_used[i] && tbl_key[i] == key) pick = i;
                    st = ST_REUSED;
                    if (pick < 0) begin
                        st = ST_NEW;
                        for (int i = 0; i < SLOTS; i++)
                            if (pick < 0 && !tbl_used[i]) pick = i;
                    end
                    if (pick < 0) begin
                        st = ST_EVICTED;
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_expired(i) &&
                                (pick < 0 || tbl_expiry[i] < tbl_expiry[pick]))
                                pick = i;
                    end
                    if (pick < 0) begin
                        add_result(0, ST_FULL, '0);
                    end else begin
                        if (dur == '0)
                            et = '0;
                        else if (tbl_now > ('1 - dur_w))
                            et = '1;
                        else
                            et = tbl_now + dur_w;
                        tbl_used[pick]   = 1'b1;
                        tbl_key[pick]    = key;
                        tbl_expiry[pick] = et;
                        add_result(pick, st, et);
                    end
                end
            end
            KIND_HIDE: begin
                for (int i = 0; i < SLOTS; i++)
                    if (pick < 0 && tbl_used[i] && tbl_key[i] == key) pick = i;
                if (pick >= 0) release_slot(pick);
            end
            KIND_CLEAR: begin
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_used[i]) release_slot(i);
            end
            default: begin
                if (tbl_now != '1) tbl_now = tbl_now + TIME_W'(1);
                if (tbl_now >= {{(TIME_W-CFG_W){1'b0}}, warmup_cfg}) tbl_warming = 1'b0;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_expired(i)) release_slot(i);
            end
        endcase
        if (results_due.size() == n0) add_result(0, ST_NOTHING, '0);
        results_due[$].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_slot_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (out_if.status < 7) status_seen[out_if.status]++;
            if (results_due.size() == 0) begin
                $error("result item with nothing expected: slot %0d status %0d",
                       out_if.slot_index, out_if.status);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (out_if.slot_index !== want.slot_index) begin
                    $error("slot_index mismatch: expected %0d, actual %0d",
                           want.slot_index, out_if.slot_index);
                    errors++;
                end
                if (out_if.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, out_if.status);
                    errors++;
                end
                if (out_if.expire_time !== want.expire_time) begin
                    $error("expire_time mismatch: expected %0h, actual %0h",
                           want.expire_time, out_if.expire_time);
                    errors++;
                end
                if (out_if.last !== want.last) begin
                    $error("last mismatch: expected %0b, actual %0b",
                           want.last, out_if.last);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result side stall pattern, with one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int rx_mode;
        int mode_left;
        bit hold_taken;
        rx_mode    = 0;
        mode_left  = 0;
        hold_taken = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_taken) begin
                hold_taken = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (rx_mode)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= 1'($urandom_range(0, 1));
                    default: out_if.ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // request side helpers; all are entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [KEY_W-1:0] key,
                                input logic [DUR_W-1:0] dur);
        in_if.valid      <= 1'b1;
        in_if.kind       <= kind;
        in_if.client_key <= key;
        in_if.duration   <= dur;
        do @(posedge i_clk); while (!in_if.ready);
        predict_request(kind, key, dur);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic pause_input(input int n);
        if (n > 0) begin
            // junk on the payload while valid is low
            in_if.valid      <= 1'b0;
            in_if.kind       <= KIND_W'($urandom_range(0, 3));
            in_if.client_key <= KEY_W'($urandom);
            in_if.duration   <= DUR_W'($urandom_range(0, 65535));
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        pause_input(1);
        while (results_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_warmup(input logic [CFG_W-1:0] value);
        wait_all_results();
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        warmup_cfg = value;
    endtask

    task automatic send_random_request();
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [DUR_W-1:0]  dur;
        int                pick;

        pick = $urandom_range(0, 99);
        if (pick < 50)      kind = KIND_SHOW;
        else if (pick < 70) kind = KIND_HIDE;
        else if (pick < 94) kind = KIND_TICK;
        else                kind = KIND_CLEAR;
        // a small key set keeps reuse and hide hits common
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
                0:       key = '0;
                1:       key = '1;
                default: key = KEY_W'(32'h5A00_0000 + $urandom_range(1, 8));
            endcase
        end else begin
            key = KEY_W'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 15)      dur = '0;
        else if (pick < 85) dur = DUR_W'($urandom_range(1, 12));
        else                dur = DUR_W'($urandom_range(0, 65535));
        send_request(kind, key, dur);
    endtask

    task automatic send_random_bursts(input int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 10);
            for (int b = 0; b < burst && sent < n; b++) begin
                send_random_request();
                sent++;
            end
            if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 8));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_warmup();
        send_request(KIND_SHOW, 32'h0000_0011, 16'd4);   // ignored while warming
        send_request(KIND_TICK, '0, '0);                 // time 1, still warming
        send_request(KIND_SHOW, 32'h0000_0011, 16'd4);
        write_warmup(8'd0);
        send_request(KIND_TICK, '0, '0);                 // warmup ends here
        send_request(KIND_SHOW, 32'h0000_0011, 16'd4);
    endtask

    task automatic test_show_hide_clear();
        send_request(KIND_SHOW, '1, '1);
        send_request(KIND_SHOW, '1, 16'd1);              // same key, slot reused
        send_request(KIND_SHOW, '0, '0);                 // never expires
        for (int k = 1; k <= 6; k++)
            send_request(KIND_SHOW, KEY_W'(k), 16'd2);
        send_request(KIND_SHOW, 32'h0000_0077, 16'd3);   // table full
        send_request(KIND_HIDE, 32'd3, '0);
        send_request(KIND_HIDE, 32'h0000_0099, '0);      // unknown key
        send_request(KIND_TICK, '0, '0);
        send_request(KIND_TICK, '0, '0);                 // several slots expire
        send_request(KIND_CLEAR, '0, '0);
        send_request(KIND_CLEAR, '0, '0);                // nothing left
        wait_all_results();
    endtask

    task automatic test_output_hold_off();
        hold_off_req = 1'b1;
        // keep offering items so the block backs up and stalls its input
        for (int k = 0; k < 24; k++)
            send_random_request();
        wait_all_results();
    endtask

    task automatic test_random_traffic(input logic [CFG_W-1:0] warmup, input int n);
        write_warmup(warmup);
        send_random_bursts(n);
        wait_all_results();
    endtask

    initial begin
        requests_sent = 0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_used[i]   = 1'b0;
            tbl_key[i]    = '0;
            tbl_expiry[i] = '0;
        end
        tbl_now     = '0;
        tbl_warming = 1'b1;
        warmup_cfg  = WARMUP_RESET;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.kind       = '0;
        in_if.client_key = '0;
        in_if.duration   = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_warmup();
        test_show_hide_clear();
        test_output_hold_off();
        test_random_traffic(8'd255, 90);
        test_random_traffic(8'd0, 90);
        test_random_traffic(8'd17, 90);

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d request items and %0d result items",
                 requests_sent, results_seen);
        $display("reused %0d, new %0d, evicted %0d, refused %0d, warmup %0d, freed %0d, none %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6]);
        if (errors == 0 && results_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
